// ===== sv/conv3x3_clamped_filter_core_defines.svh =====
// assertion macros shared by the filter core
`ifndef CONV3X3_CLAMPED_FILTER_CORE_DEFINES_SVH
`define CONV3X3_CLAMPED_FILTER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define C3F_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define C3F_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/c3f_pkg.sv =====
// shared types, constants and register codes of the 3x3 filter
package c3f_pkg;

  localparam int PIX_BITS  = 8;
  localparam int LANES     = 3;
  localparam int ROW_BITS  = 16;
  localparam int WREG_BITS = 11;
  localparam int KROW_BITS = 36;
  localparam int FRAC_BITS = 4;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int COEF_BITS_DEF = 12;

  localparam int QDEPTH     = 4;
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);
  localparam int ODEPTH     = 8;
  localparam int OCNT_BITS  = $clog2(ODEPTH + 1);

  localparam int DATA_BITS    = 64;
  localparam int ADDR_BITS    = 6;
  localparam int REG_IDX_BITS = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_COLOR_MODE   = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_KERNEL_TOP   = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_KERNEL_MID   = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_KERNEL_BOT   = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_FRAC_SHIFT   = 3'd6;

  localparam logic [WREG_BITS-1:0] IMAGE_WIDTH_RST  = 11'd1024;
  localparam logic [ROW_BITS-1:0]  IMAGE_HEIGHT_RST = 16'd480;

  localparam logic [PIX_BITS-1:0] PIX_MAX = 8'd255;

  typedef logic [LANES-1:0][PIX_BITS-1:0] lanes_t;
  // one window column, indexed by row, top row first
  typedef lanes_t [2:0] column_t;
  // full window, indexed by column, left column first
  typedef column_t [2:0] window_t;

  typedef struct packed {
    window_t               px;
    logic [ROW_BITS-1:0]   row;
    logic                  last;
  } win_item_t;

  typedef struct packed {
    logic [ROW_BITS-1:0]   row;
    lanes_t                val;
    logic                  last;
  } res_item_t;

  typedef struct packed {
    logic [2:0][KROW_BITS-1:0] kern;
    logic [FRAC_BITS-1:0]      frac_shift;
    logic                      color_mode;
  } cfg_t;

endpackage

// ===== sv/c3f_ram.sv =====
// generic single-write, single-read ram with registered read data
module c3f_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/c3f_fifo.sv =====
// small register queue with show-ahead output
module c3f_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNTW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// ===== sv/c3f_front.sv =====
// front end: raster counters, line stores and window assembly
module c3f_front #(
  parameter int MAX_WIDTH = c3f_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  c3f_pkg::lanes_t                   pixel,
  input  logic [c3f_pkg::WREG_BITS-1:0]     image_width,
  input  logic [c3f_pkg::ROW_BITS-1:0]      image_height,
  output logic                              s1_valid,
  output logic                              item_valid,
  output c3f_pkg::win_item_t                item,
  output logic [$clog2(MAX_WIDTH)-1:0]      item_col
);
  import c3f_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int LW = LANES * PIX_BITS;

  logic [CW-1:0]       column_count;
  logic [ROW_BITS-1:0] row_count;
  logic [WW-1:0]       w_eff;
  logic [ROW_BITS-1:0] h_eff;
  logic [CW-1:0]       col;
  logic                end_row;
  logic                end_img;
  logic                has_res;

  logic [CW-1:0]       s1_col;
  logic [ROW_BITS-1:0] s1_row;
  lanes_t              s1_px;
  logic                s1_res;
  logic                s1_last;

  logic [LW-1:0]       upper_rd;
  logic [LW-1:0]       lower_rd;
  column_t             cur;
  column_t             win0;
  column_t             win1;

  always_comb begin
    if (image_width < 11'd3) begin
      w_eff = WW'(3);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    h_eff   = (image_height < 16'd3) ? 16'd3 : image_height;
    col     = (WW'(column_count) >= w_eff) ? CW'(w_eff - WW'(1)) : column_count;
    end_row = (WW'(col) == w_eff - WW'(1));
    end_img = end_row && (row_count >= h_eff - 16'd1);
    has_res = (row_count >= 16'd2) && (WW'(col) >= WW'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (end_row) begin
          column_count <= '0;
          row_count    <= end_img ? '0 : row_count + 16'd1;
        end else begin
          column_count <= col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col  <= col;
      s1_row  <= row_count;
      s1_px   <= pixel;
      s1_res  <= has_res;
      s1_last <= end_img;
    end
  end

  // rows r-2 and r-1 arrive in the cycle after the read
  c3f_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (lower_rd),
    .re    (accept),
    .raddr (col),
    .rdata (upper_rd)
  );

  c3f_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_lower (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (s1_px),
    .re    (accept),
    .raddr (col),
    .rdata (lower_rd)
  );

  always_comb begin
    cur[0] = upper_rd;
    cur[1] = lower_rd;
    cur[2] = s1_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win0 <= '0;
      win1 <= '0;
    end else if (s1_valid) begin
      win0 <= win1;
      win1 <= cur;
    end
  end

  assign item_valid = s1_valid && s1_res;
  assign item.px[0] = win0;
  assign item.px[1] = win1;
  assign item.px[2] = cur;
  assign item.row   = s1_row - 16'd1;
  assign item.last  = s1_last;
  assign item_col   = s1_col - CW'(1);

endmodule

// ===== sv/c3f_back.sv =====
// back end: multiply, sum, shift and clamp pipeline
module c3f_back #(
  parameter int COEF_BITS = c3f_pkg::COEF_BITS_DEF,
  parameter int MAX_WIDTH = c3f_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  c3f_pkg::cfg_t                 cfg,
  input  logic                          q_empty,
  input  c3f_pkg::win_item_t            q_item,
  input  logic [$clog2(MAX_WIDTH)-1:0]  q_col,
  output logic                          q_pop,
  input  logic [c3f_pkg::OCNT_BITS-1:0] o_count,
  output logic                          o_push,
  output c3f_pkg::res_item_t            o_item,
  output logic [$clog2(MAX_WIDTH)-1:0]  o_col
);
  import c3f_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int PW  = COEF_BITS + PIX_BITS + 1;
  localparam int RW  = PW + 2;
  localparam int SW  = PW + 4;
  localparam int KPW = (3 * COEF_BITS > KROW_BITS) ? 3 * COEF_BITS : KROW_BITS;

  logic [KPW-1:0]              kpad [3];
  logic signed [COEF_BITS-1:0] coef [3][3];

  logic                 b1v, b2v, b3v;
  logic signed [PW-1:0] b1_prod [LANES][3][3];
  logic signed [RW-1:0] b2_rsum [LANES][3];
  logic signed [SW-1:0] total   [LANES];
  logic [SW-1:0]        shifted [LANES];
  lanes_t               clamped;

  logic [ROW_BITS-1:0] b1_row, b2_row, b3_row;
  logic [CW-1:0]       b1_col, b2_col, b3_col;
  logic                b1_last, b2_last, b3_last;
  lanes_t              b3_val;

  // coefficients: left column in the low bits of each row register
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      kpad[i] = KPW'(cfg.kern[i]);
      for (int j = 0; j < 3; j++) begin
        coef[i][j] = kpad[i][j*COEF_BITS +: COEF_BITS];
      end
    end
  end

  // credit: results in flight plus queued results never exceed the output queue
  assign q_pop = !q_empty &&
                 ((32'(o_count) + 32'(b1v) + 32'(b2v) + 32'(b3v)) < ODEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1v <= 1'b0;
      b2v <= 1'b0;
      b3v <= 1'b0;
    end else begin
      b1v <= q_pop;
      b2v <= b1v;
      b3v <= b2v;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int l = 0; l < LANES; l++) begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            b1_prod[l][i][j] <= $signed({1'b0, q_item.px[j][i][l]}) * coef[i][j];
          end
        end
      end
      b1_row  <= q_item.row;
      b1_col  <= q_col;
      b1_last <= q_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (b1v) begin
      for (int l = 0; l < LANES; l++) begin
        for (int i = 0; i < 3; i++) begin
          b2_rsum[l][i] <= RW'(b1_prod[l][i][0]) + RW'(b1_prod[l][i][1]) +
                           RW'(b1_prod[l][i][2]);
        end
      end
      b2_row  <= b1_row;
      b2_col  <= b1_col;
      b2_last <= b1_last;
    end
  end

  // negative sums give zero, large ones saturate; in gray mode lanes 1 and 2 give zero
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      total[l]   = SW'(b2_rsum[l][0]) + SW'(b2_rsum[l][1]) + SW'(b2_rsum[l][2]);
      shifted[l] = $unsigned(total[l]) >> cfg.frac_shift;
      if (total[l][SW-1] || (l != 0 && !cfg.color_mode)) begin
        clamped[l] = '0;
      end else if (shifted[l] > SW'(PIX_MAX)) begin
        clamped[l] = PIX_MAX;
      end else begin
        clamped[l] = shifted[l][PIX_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b2v) begin
      b3_val  <= clamped;
      b3_row  <= b2_row;
      b3_col  <= b2_col;
      b3_last <= b2_last;
    end
  end

  assign o_push      = b3v;
  assign o_item.row  = b3_row;
  assign o_item.val  = b3_val;
  assign o_item.last = b3_last;
  assign o_col       = b3_col;

endmodule

// ===== sv/conv3x3_clamped_filter_core.sv =====
// top level of the streaming 3x3 clamped convolution filter
// path: a pixel completing a window passes the front stage, the window queue, stages b1 to b3 and the result queue
// throughput: one pixel per cycle while full is low, set by one line store read
//   per pixel and the fully pipelined nine-tap multiply and sum per lane
// reset: counters, window, queues and pipeline valids cleared at once; line
//   stores are not cleared and need no clearing pass
`include "conv3x3_clamped_filter_core_defines.svh"

module conv3x3_clamped_filter_core #(
  parameter int MAX_WIDTH = c3f_pkg::MAX_WIDTH_DEF,
  parameter int COEF_BITS = c3f_pkg::COEF_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // pixel input side
  input  logic                              push,
  output logic                              full,
  input  logic [c3f_pkg::PIX_BITS-1:0]      red_or_gray,
  input  logic [c3f_pkg::PIX_BITS-1:0]      green_in,
  input  logic [c3f_pkg::PIX_BITS-1:0]      blue_in,
  // result side
  output logic                              empty,
  input  logic                              pop,
  output logic [c3f_pkg::ROW_BITS-1:0]      centre_row,
  output logic [$clog2(MAX_WIDTH)-1:0]      centre_col,
  output logic [c3f_pkg::PIX_BITS-1:0]      out_red_or_gray,
  output logic [c3f_pkg::PIX_BITS-1:0]      out_green,
  output logic [c3f_pkg::PIX_BITS-1:0]      out_blue,
  output logic                              last_result,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [c3f_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [c3f_pkg::DATA_BITS-1:0]     pwdata,
  output logic [c3f_pkg::DATA_BITS-1:0]     prdata,
  output logic                              pready
);
  import c3f_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int QW = CW + $bits(win_item_t);
  localparam int OW = CW + $bits(res_item_t);

  // configuration registers
  logic [WREG_BITS-1:0]  image_width;
  logic [ROW_BITS-1:0]   image_height;
  logic                  color_mode;
  logic [KROW_BITS-1:0]  kernel_top_row;
  logic [KROW_BITS-1:0]  kernel_mid_row;
  logic [KROW_BITS-1:0]  kernel_bottom_row;
  logic [FRAC_BITS-1:0]  frac_shift;
  logic [REG_IDX_BITS-1:0] reg_idx;
  logic                  cfg_wr;
  cfg_t                  cfg;

  // front to queue
  logic                  accept;
  lanes_t                pixel;
  logic                  s1_valid;
  logic                  q_push;
  win_item_t             q_in_item;
  logic [CW-1:0]         q_in_col;
  logic [QW-1:0]         q_dout;
  logic                  q_full;
  logic                  q_empty;
  logic [QCNT_BITS-1:0]  q_count;
  logic                  q_pop;
  win_item_t             q_item;
  logic [CW-1:0]         q_col;

  // back to output queue
  logic                  o_push;
  res_item_t             o_in_item;
  logic [CW-1:0]         o_in_col;
  logic [OW-1:0]         o_dout;
  logic                  o_full;
  logic [OCNT_BITS-1:0]  o_count;
  res_item_t             o_item;

  // register port: 8-byte stride, the index sits above the byte offset
  assign reg_idx = paddr[ADDR_BITS-1:3];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= IMAGE_WIDTH_RST;
      image_height      <= IMAGE_HEIGHT_RST;
      color_mode        <= 1'b1;
      kernel_top_row    <= '0;
      kernel_mid_row    <= '0;
      kernel_bottom_row <= '0;
      frac_shift        <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH:  image_width       <= pwdata[WREG_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height      <= pwdata[ROW_BITS-1:0];
        REG_COLOR_MODE:   color_mode        <= pwdata[0];
        REG_KERNEL_TOP:   kernel_top_row    <= pwdata[KROW_BITS-1:0];
        REG_KERNEL_MID:   kernel_mid_row    <= pwdata[KROW_BITS-1:0];
        REG_KERNEL_BOT:   kernel_bottom_row <= pwdata[KROW_BITS-1:0];
        REG_FRAC_SHIFT:   frac_shift        <= pwdata[FRAC_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = DATA_BITS'(image_width);
      REG_IMAGE_HEIGHT: prdata = DATA_BITS'(image_height);
      REG_COLOR_MODE:   prdata = DATA_BITS'(color_mode);
      REG_KERNEL_TOP:   prdata = DATA_BITS'(kernel_top_row);
      REG_KERNEL_MID:   prdata = DATA_BITS'(kernel_mid_row);
      REG_KERNEL_BOT:   prdata = DATA_BITS'(kernel_bottom_row);
      REG_FRAC_SHIFT:   prdata = DATA_BITS'(frac_shift);
      default:          prdata = '0;
    endcase
  end

  assign cfg.kern[0]    = kernel_top_row;
  assign cfg.kern[1]    = kernel_mid_row;
  assign cfg.kern[2]    = kernel_bottom_row;
  assign cfg.frac_shift = frac_shift;
  assign cfg.color_mode = color_mode;

  // input side: hold off when the queued windows plus the item now in the front stage fill the window queue
  assign full     = (32'(q_count) + 32'(s1_valid)) >= QDEPTH;
  assign accept   = push && !full;
  assign pixel[0] = red_or_gray;
  assign pixel[1] = green_in;
  assign pixel[2] = blue_in;

  c3f_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .pixel        (pixel),
    .image_width  (image_width),
    .image_height (image_height),
    .s1_valid     (s1_valid),
    .item_valid   (q_push),
    .item         (q_in_item),
    .item_col     (q_in_col)
  );

  // windows waiting for the arithmetic
  c3f_fifo #(.WIDTH(QW), .DEPTH(QDEPTH)) u_win_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   ({q_in_col, q_in_item}),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty),
    .count (q_count)
  );

  assign {q_col, q_item} = q_dout;

  c3f_back #(.COEF_BITS(COEF_BITS), .MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_item  (q_item),
    .q_col   (q_col),
    .q_pop   (q_pop),
    .o_count (o_count),
    .o_push  (o_push),
    .o_item  (o_in_item),
    .o_col   (o_in_col)
  );

  // finished results wait here for the consumer
  c3f_fifo #(.WIDTH(OW), .DEPTH(ODEPTH)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (o_push),
    .din   ({o_in_col, o_in_item}),
    .pop   (pop),
    .dout  (o_dout),
    .full  (o_full),
    .empty (empty),
    .count (o_count)
  );

  assign {centre_col, o_item} = o_dout;
  assign centre_row      = o_item.row;
  assign out_red_or_gray = o_item.val[0];
  assign out_green       = o_item.val[1];
  assign out_blue        = o_item.val[2];
  assign last_result     = o_item.last;

  // checks on the internal flow control and on the results
  `C3F_ASSERT_IMPLIES(a_win_q_no_overflow, q_push, !q_full, "window queue overflow")
  `C3F_ASSERT_IMPLIES(a_res_q_no_overflow, o_push, !o_full, "result queue overflow")
  `C3F_ASSERT_NEXT(a_front_stage_follows, accept, s1_valid, "accepted pixel lost in front")
  `C3F_ASSERT_IMPLIES(a_interior_centre, !empty, |centre_row && |centre_col, "border centre")
  `C3F_ASSERT_IMPLIES(a_gray_lanes_zero, !empty && !color_mode, ~|{out_green, out_blue}, "gray")

endmodule
